>>> rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants for the HSL to RGB converter
// Fixed-point widths, hue-turn constants and the ramp slope function.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned HUE_W  = 16;  // Q0.16 hue
  localparam int unsigned UNIT_W = 17;  // Q1.16 saturation / lightness
  localparam int unsigned SL_W   = 34;  // s * l
  localparam int unsigned POS_W  = 18;  // ramp position, units of 1/(3*65536) turn
  localparam int unsigned LVL_W  = 33;  // Q1.32 levels
  localparam int unsigned PROD_W = 51;  // d * k
  localparam int unsigned NUM_W  = 50;  // level numerator over 3 * 2^48
  localparam int unsigned MUL_W  = 57;  // 85 * numerator
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NCH    = 3;   // red, green, blue lanes

  localparam logic [UNIT_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [UNIT_W-1:0] HALF_Q16 = 17'd32768;

  localparam logic [POS_W-1:0] TURN      = 18'd196608;
  localparam logic [POS_W-1:0] THIRD     = 18'd65536;
  localparam logic [POS_W-1:0] TWO_THIRD = 18'd131072;
  localparam logic [POS_W-1:0] SIXTH     = 18'd32768;
  localparam logic [POS_W-1:0] HALF_TURN = 18'd98304;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [UNIT_W-1:0] sat;
    logic [UNIT_W-1:0] light;
    logic [SL_W-1:0]   sl;
    pos_t [NCH-1:0]    pos;   // lane 0 red, 1 green, 2 blue
  } prep_t;

  typedef struct packed {
    logic [LVL_W-1:0] v1;
    logic [LVL_W-1:0] d;      // v2 - v1, never negative
    pos_t [NCH-1:0]   k;      // ramp weight over one turn
  } ramp_t;

  // Weight of (v2 - v1) at position t, over a denominator of one turn.
  function automatic pos_t ramp_k(input pos_t t);
    logic [20:0] six_t;
    logic [20:0] fall;
    pos_t        k;
    six_t = (21'(t) << 2) + (21'(t) << 1);
    fall  = (21'(TURN) << 2) - six_t;
    if (t < SIXTH) begin
      k = six_t[POS_W-1:0];
    end else if (t < HALF_TURN) begin
      k = TURN;
    end else if (t < TWO_THIRD) begin
      k = fall[POS_W-1:0];
    end else begin
      k = '0;
    end
    return k;
  endfunction

endpackage

>>> rtl/h2r_prep.sv
// ----------------------------------------------------------------------------
// h2r_prep: first pipeline stage
// Clamps saturation and lightness, forms s*l and the three hue positions.
// ----------------------------------------------------------------------------
module h2r_prep
  import h2r_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [HUE_W-1:0]  hue,
  input  logic [UNIT_W-1:0] saturation,
  input  logic [UNIT_W-1:0] lightness,
  output logic              out_valid,
  output prep_t             out_data
);

  logic              valid_r;
  prep_t             data_r;
  prep_t             data_nxt;
  logic [UNIT_W-1:0] s_c;
  logic [UNIT_W-1:0] l_c;
  pos_t              h3;
  logic [POS_W:0]    tr_w;

  always_comb begin
    s_c  = (saturation > ONE_Q16) ? ONE_Q16 : saturation;
    l_c  = (lightness  > ONE_Q16) ? ONE_Q16 : lightness;
    h3   = (POS_W'(hue) << 1) + POS_W'(hue);
    tr_w = {1'b0, h3} + {1'b0, THIRD};

    data_nxt.sat   = s_c;
    data_nxt.light = l_c;
    data_nxt.sl    = SL_W'(s_c) * SL_W'(l_c);
    // red: a position of exactly one turn is kept unwrapped
    data_nxt.pos[0] = (tr_w > {1'b0, TURN}) ? POS_W'(tr_w - {1'b0, TURN}) : tr_w[POS_W-1:0];
    data_nxt.pos[1] = h3;
    data_nxt.pos[2] = (h3 < THIRD) ? (h3 + TWO_THIRD) : (h3 - THIRD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> rtl/h2r_ramp.sv
// ----------------------------------------------------------------------------
// h2r_ramp: second pipeline stage
// Forms the two levels v1, v2 (as v1 and d = v2 - v1) and the ramp weights.
// ----------------------------------------------------------------------------
module h2r_ramp
  import h2r_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  prep_t in_data,
  output logic  out_valid,
  output ramp_t out_data
);

  logic        valid_r;
  ramp_t       data_r;
  ramp_t       data_nxt;
  logic [34:0] v2_w;
  logic [34:0] v1_w;
  logic [LVL_W-1:0] v2;

  always_comb begin
    // low lightness: l*(1+s); otherwise l + s - s*l
    if (in_data.light < HALF_Q16) begin
      v2_w = (35'(in_data.light) << 16) + 35'(in_data.sl);
    end else begin
      v2_w = (35'(in_data.light) << 16) + (35'(in_data.sat) << 16) - 35'(in_data.sl);
    end
    v2   = v2_w[LVL_W-1:0];
    v1_w = (35'(in_data.light) << 17) - 35'(v2);

    data_nxt.v1 = v1_w[LVL_W-1:0];
    data_nxt.d  = v2 - v1_w[LVL_W-1:0];
    for (int i = 0; i < NCH; i++) begin
      data_nxt.k[i] = ramp_k(in_data.pos[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> rtl/h2r_chan.sv
// ----------------------------------------------------------------------------
// h2r_chan: channel stages, three lanes side by side
// Multiply d*k, add v1 over one turn, scale by 255 and take the integer part, capped at 255.
// ----------------------------------------------------------------------------
module h2r_chan
  import h2r_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  ramp_t                     in_data,
  output logic                      out_valid,
  output logic [NCH-1:0][CH_W-1:0]  out_ch
);

  // multiply stage
  logic                         v_mul_r;
  logic [LVL_W-1:0]             v1_r;
  logic [NCH-1:0][PROD_W-1:0]   p_r;
  // accumulate stage
  logic                         v_num_r;
  logic [NCH-1:0][NUM_W-1:0]    num_r;
  logic [NCH-1:0][NUM_W-1:0]    num_nxt;
  // scale stage
  logic                         v_ch_r;
  logic [NCH-1:0][CH_W-1:0]     ch_r;
  logic [NCH-1:0][CH_W-1:0]     ch_nxt;
  logic [NCH-1:0][MUL_W-1:0]    m;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      // v1 * 3 * 2^16 plus d*k
      num_nxt[i] = (NUM_W'(v1_r) << 17) + (NUM_W'(v1_r) << 16) + NUM_W'(p_r[i]);
      // 255 / (3 * 2^48) = 85 / 2^48
      m[i] = (MUL_W'(num_r[i]) << 6) + (MUL_W'(num_r[i]) << 4)
           + (MUL_W'(num_r[i]) << 2) + MUL_W'(num_r[i]);
      ch_nxt[i] = (m[i][MUL_W-1:48] > 9'(CH_MAX)) ? CH_MAX : m[i][55:48];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mul_r <= 1'b0;
      v_num_r <= 1'b0;
      v_ch_r  <= 1'b0;
    end else if (en) begin
      v_mul_r <= in_valid;
      v_num_r <= v_mul_r;
      v_ch_r  <= v_num_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r <= in_data.v1;
      for (int i = 0; i < NCH; i++) begin
        p_r[i] <= PROD_W'(in_data.d) * PROD_W'(in_data.k[i]);
      end
      num_r <= num_nxt;
      ch_r  <= ch_nxt;
    end
  end

  assign out_valid = v_ch_r;
  assign out_ch    = ch_r;

endmodule

>>> rtl/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter: HSL to RGB colour conversion, one pixel per clock unless stalled
// Exact fixed-point HSL to 8-bit RGB over a five-stage pipeline.
// ----------------------------------------------------------------------------
// One pixel enters per clock and throughput is one transfer per cycle for
// as long as the output side takes data. The five register stages are:
// clamp and s*l product, level and ramp weight, d*k multiply, level
// numerator, scale by 255. The whole pipeline holds when the output
// transfer is stalled, so nothing is dropped or repeated. Saturation and
// lightness above 1.0 are clamped to 1.0; a hue position is a fraction of
// a full turn. Every channel is the exact floor of 255 times the level
// (no rounding anywhere), grey when saturation is zero.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
  import h2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // hue[15:0], saturation[32:16], lightness[49:33], [55:50] unused
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic                     en;
  logic                     prep_valid;
  prep_t                    prep_data;
  logic                     ramp_valid;
  ramp_t                    ramp_data;
  logic                     ch_valid;
  logic [NCH-1:0][CH_W-1:0] ch;

  // Pipeline advances unless a finished result is held by the sink.
  assign en        = !ch_valid || out_tready;
  assign in_tready = en;

  h2r_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .hue        (in_tdata[15:0]),
    .saturation (in_tdata[32:16]),
    .lightness  (in_tdata[49:33]),
    .out_valid  (prep_valid),
    .out_data   (prep_data)
  );

  h2r_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_valid),
    .in_data   (prep_data),
    .out_valid (ramp_valid),
    .out_data  (ramp_data)
  );

  // lanes: 0 red, 1 green, 2 blue
  h2r_chan u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ramp_valid),
    .in_data   (ramp_data),
    .out_valid (ch_valid),
    .out_ch    (ch)
  );

  assign out_tvalid = ch_valid;
  assign out_tdata  = {ch[2], ch[1], ch[0]};

endmodule
